// ----- design/ckc_pkg.sv -----
// Shared types, opcodes and constants for the canonical k-mer segment counter.
// Holds the nucleotide complement function used by the pattern store and the scanner.
// No dependencies.
`default_nettype none

package ckc_pkg;

    // Opcodes carried in the input tuser field.
    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_LOAD  = 3'd1,
        OP_NODE  = 3'd2,
        OP_END   = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    // Width and saturation limit of one occurrence count.
    localparam int            COUNT_W   = 31;
    localparam logic [30:0]   COUNT_MAX = 31'h7FFF_FFFF;

    // Nucleotide bytes.
    localparam logic [7:0] SYM_A = 8'h61;
    localparam logic [7:0] SYM_C = 8'h63;
    localparam logic [7:0] SYM_G = 8'h67;
    localparam logic [7:0] SYM_N = 8'h6E;
    localparam logic [7:0] SYM_T = 8'h74;

    // Decoded command for one executing beat.
    typedef struct packed {
        logic       clear;
        logic       load;
        logic       node;
        logic       end_node;
        logic       last;
        logic [3:0] idx;
        logic [4:0] pos;
        logic [7:0] sym;
    } t_ctrl;

    // Complement of one byte: a and t swap, g and c swap, anything else becomes n.
    function automatic logic [7:0] complement_of(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            SYM_A:   r = SYM_T;
            SYM_T:   r = SYM_A;
            SYM_G:   r = SYM_C;
            SYM_C:   r = SYM_G;
            default: r = SYM_N;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/ckc_pattern_store.sv -----
// Pattern store: symbol rows, reversed rows, lengths and canonical/palindrome flags.
// On the last symbol of a pattern it builds the reversed row and both flags while that symbol is stored.
// Depends on ckc_pkg.
`default_nettype none

module ckc_pattern_store #(
    parameter int  NUM_PATTERNS       = 16,
    parameter int  MAX_PATTERN_LENGTH = 32,
    localparam int LEN_W              = $clog2(MAX_PATTERN_LENGTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ckc_pkg::t_ctrl   i_ctrl,
    output logic [7:0]            o_sym [NUM_PATTERNS][MAX_PATTERN_LENGTH],
    output logic [7:0]            o_rev [NUM_PATTERNS][MAX_PATTERN_LENGTH],
    output logic [LEN_W-1:0]      o_len [NUM_PATTERNS],
    output logic                  o_canon [NUM_PATTERNS],
    output logic                  o_pal [NUM_PATTERNS]
);

    logic [7:0]              r_sym [NUM_PATTERNS][MAX_PATTERN_LENGTH];
    logic [7:0]              r_rev [NUM_PATTERNS][MAX_PATTERN_LENGTH];
    logic [LEN_W-1:0]        r_len [NUM_PATTERNS];
    logic                    r_canon [NUM_PATTERNS];
    logic                    r_pal [NUM_PATTERNS];

    logic                    pos_ok;
    logic [7:0]              row [MAX_PATTERN_LENGTH];
    logic [7:0]              row_m [MAX_PATTERN_LENGTH];
    logic [7:0]              rev_new [MAX_PATTERN_LENGTH];
    logic [MAX_PATTERN_LENGTH-1:0] lt;
    logic [MAX_PATTERN_LENGTH-1:0] gt;
    logic [MAX_PATTERN_LENGTH-1:0] diff;
    logic [MAX_PATTERN_LENGTH-1:0] lowbit;
    logic                    canon_new;
    logic                    pal_new;
    logic [LEN_W-1:0]        len_new;

    assign pos_ok  = int'(i_ctrl.pos) < MAX_PATTERN_LENGTH;
    assign len_new = LEN_W'(i_ctrl.pos) + 1'b1;

    // Select the addressed row, merge in the new symbol, reverse it by length
    // and compare it byte-wise against its reverse complement.
    always_comb begin
        for (int j = 0; j < MAX_PATTERN_LENGTH; j++) begin
            row[j] = 8'd0;
        end
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            for (int j = 0; j < MAX_PATTERN_LENGTH; j++) begin
                row[j] = row[j] | (r_sym[p][j] & {8{int'(i_ctrl.idx) == p}});
            end
        end
        for (int j = 0; j < MAX_PATTERN_LENGTH; j++) begin
            row_m[j] = (int'(i_ctrl.pos) == j) ? i_ctrl.sym : row[j];
        end
        for (int k = 0; k < MAX_PATTERN_LENGTH; k++) begin
            rev_new[k] = 8'd0;
            for (int j = 0; j < MAX_PATTERN_LENGTH; j++) begin
                if (int'(i_ctrl.pos) - k == j) begin
                    rev_new[k] = rev_new[k] | row_m[j];
                end
            end
        end
        for (int j = 0; j < MAX_PATTERN_LENGTH; j++) begin
            lt[j] = (j <= int'(i_ctrl.pos)) && (row_m[j] < ckc_pkg::complement_of(rev_new[j]));
            gt[j] = (j <= int'(i_ctrl.pos)) && (row_m[j] > ckc_pkg::complement_of(rev_new[j]));
        end
        // The lowest differing byte decides the ordering.
        diff      = lt | gt;
        lowbit    = diff & (~diff + 1'b1);
        pal_new   = (diff == '0);
        canon_new = pal_new || ((lowbit & lt) != '0);
    end

    // Symbol and reversed rows carry no reset.
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            if (i_ctrl.load && pos_ok && (int'(i_ctrl.idx) == p)) begin
                for (int j = 0; j < MAX_PATTERN_LENGTH; j++) begin
                    if (int'(i_ctrl.pos) == j) begin
                        r_sym[p][j] <= i_ctrl.sym;
                    end
                end
                if (i_ctrl.last) begin
                    r_rev[p] <= rev_new;
                end
            end
        end
    end

    // Length and flags: zero marks a pattern as unused.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                r_len[p]   <= '0;
                r_canon[p] <= 1'b0;
                r_pal[p]   <= 1'b0;
            end
        end else begin
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                if (i_ctrl.load && pos_ok && (int'(i_ctrl.idx) == p)) begin
                    if (i_ctrl.last) begin
                        r_len[p]   <= len_new;
                        r_canon[p] <= canon_new;
                        r_pal[p]   <= pal_new;
                    end else begin
                        r_len[p]   <= '0;
                        r_canon[p] <= 1'b0;
                        r_pal[p]   <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_sym   = r_sym;
    assign o_rev   = r_rev;
    assign o_len   = r_len;
    assign o_canon = r_canon;
    assign o_pal   = r_pal;

endmodule

`default_nettype wire

// ----- design/ckc_scan.sv -----
// Scanner: history window, fill level and saturating occurrence counts.
// Every node beat compares all stored patterns against the window in parallel.
// Depends on ckc_pkg.
`default_nettype none

module ckc_scan #(
    parameter int  NUM_PATTERNS       = 16,
    parameter int  MAX_PATTERN_LENGTH = 32,
    localparam int LEN_W              = $clog2(MAX_PATTERN_LENGTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ckc_pkg::t_ctrl   i_ctrl,
    input  wire logic [7:0]       i_sym [NUM_PATTERNS][MAX_PATTERN_LENGTH],
    input  wire logic [7:0]       i_rev [NUM_PATTERNS][MAX_PATTERN_LENGTH],
    input  wire logic [LEN_W-1:0] i_len [NUM_PATTERNS],
    input  wire logic             i_canon [NUM_PATTERNS],
    input  wire logic             i_pal [NUM_PATTERNS],
    output logic [ckc_pkg::COUNT_W-1:0] o_count [NUM_PATTERNS]
);

    logic [7:0]                   r_win [MAX_PATTERN_LENGTH];
    logic [7:0]                   n_win [MAX_PATTERN_LENGTH];
    logic [LEN_W-1:0]             r_fill;
    logic [LEN_W-1:0]             n_fill;
    logic [ckc_pkg::COUNT_W-1:0]  r_count [NUM_PATTERNS];
    logic [ckc_pkg::COUNT_W-1:0]  n_count [NUM_PATTERNS];

    logic                         fwd [NUM_PATTERNS];
    logic                         rcm [NUM_PATTERNS];
    logic                         hit [NUM_PATTERNS];
    logic [1:0]                   add [NUM_PATTERNS];
    logic [ckc_pkg::COUNT_W:0]    sum [NUM_PATTERNS];

    // Window after the new symbol shifts in; the newest symbol sits at index zero.
    always_comb begin
        n_win[0] = i_ctrl.sym;
        for (int k = 1; k < MAX_PATTERN_LENGTH; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_fill = (int'(r_fill) < MAX_PATTERN_LENGTH) ? r_fill + 1'b1 : r_fill;
    end

    // Per-pattern forward and reverse-complement comparison and saturating add.
    always_comb begin
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            fwd[p] = 1'b1;
            rcm[p] = 1'b1;
            for (int k = 0; k < MAX_PATTERN_LENGTH; k++) begin
                if (k < int'(i_len[p])) begin
                    if (i_rev[p][k] != n_win[k]) begin
                        fwd[p] = 1'b0;
                    end
                    if (ckc_pkg::complement_of(i_sym[p][k]) != n_win[k]) begin
                        rcm[p] = 1'b0;
                    end
                end
            end
            hit[p] = (i_len[p] != '0) && (i_len[p] <= n_fill) && i_canon[p];
            add[p] = {1'b0, hit[p] && fwd[p]} + {1'b0, hit[p] && rcm[p] && !i_pal[p]};
            sum[p] = {1'b0, r_count[p]} + {{(ckc_pkg::COUNT_W-1){1'b0}}, add[p]};
            n_count[p] = (sum[p] > {1'b0, ckc_pkg::COUNT_MAX}) ?
                         ckc_pkg::COUNT_MAX : sum[p][ckc_pkg::COUNT_W-1:0];
        end
    end

    // Window, fill and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN_LENGTH; k++) begin
                r_win[k] <= 8'd0;
            end
            r_fill <= '0;
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                r_count[p] <= '0;
            end
        end else begin
            if (i_ctrl.node) begin
                r_win  <= n_win;
                r_fill <= n_fill;
                r_count <= n_count;
            end else if (i_ctrl.end_node) begin
                for (int k = 0; k < MAX_PATTERN_LENGTH; k++) begin
                    r_win[k] <= 8'd0;
                end
                r_fill <= '0;
            end else if (i_ctrl.clear) begin
                for (int p = 0; p < NUM_PATTERNS; p++) begin
                    r_count[p] <= '0;
                end
            end
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- design/canonical_kmer_segment_counter.sv -----
// Top level of the canonical k-mer segment counter: input register, decode,
// result register and handshakes. Depends on ckc_pkg, ckc_pattern_store and ckc_scan.
//
// Usage:
//   The slave stream carries one command beat: tuser holds the opcode (clear counts,
//   load pattern symbol, node symbol, end of node, read count), tdata holds the
//   pattern index, symbol position and symbol byte, and tlast marks the final
//   symbol of a loaded pattern. Only a read command produces a master beat, which
//   returns the pattern index and its saturating 31-bit count.
//   Throughput: one beat per cycle for every opcode while reads are not held up.
//   A beat is captured in the input register and then executes from there: the
//   pattern store, the parallel window comparators and the count adders update
//   all state at once, so each command sees everything its predecessors left behind.
//   A read result is held in the result register once the read executes.
//   When the master side stalls, non-read beats keep flowing; a read beat waits in
//   the input register until the result register frees, and tready drops only then.
//   Reset clears lengths, flags, counts, window and fill, leaving all patterns
//   unused; pattern symbol storage is not cleared and needs no clearing pass.
`default_nettype none

module canonical_kmer_segment_counter #(
    parameter int NUM_PATTERNS       = 16,
    parameter int MAX_PATTERN_LENGTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // pattern_index[3:0], position[8:4], symbol[16:9], zero
    input  wire logic [2:0]  s_axis_tuser,   // opcode[2:0]
    input  wire logic        s_axis_tlast,   // last_symbol
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata    // read_index[3:0], match_count[34:4], zero
);

    localparam int LEN_W = $clog2(MAX_PATTERN_LENGTH + 1);

    // Input register.
    logic        r_in_valid;
    logic [2:0]  r_in_op;
    logic [3:0]  r_in_idx;
    logic [4:0]  r_in_pos;
    logic [7:0]  r_in_sym;
    logic        r_in_last;

    // Result register.
    logic        r_out_valid;
    logic [3:0]  r_out_idx;
    logic [ckc_pkg::COUNT_W-1:0] r_out_count;

    logic        is_read;
    logic        out_free;
    logic        go;
    ckc_pkg::t_ctrl ctrl;
    logic [ckc_pkg::COUNT_W-1:0] read_count;

    logic [7:0]              pat_sym [NUM_PATTERNS][MAX_PATTERN_LENGTH];
    logic [7:0]              pat_rev [NUM_PATTERNS][MAX_PATTERN_LENGTH];
    logic [LEN_W-1:0]        pat_len [NUM_PATTERNS];
    logic                    pat_canon [NUM_PATTERNS];
    logic                    pat_pal [NUM_PATTERNS];
    logic [ckc_pkg::COUNT_W-1:0] counts [NUM_PATTERNS];

    // Handshake: the held beat executes unless it is a read facing a full, stalled result slot.
    assign is_read       = (ckc_pkg::t_op'(r_in_op) == ckc_pkg::OP_READ);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign go            = r_in_valid && (!is_read || out_free);
    assign s_axis_tready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_idx  <= s_axis_tdata[3:0];
            r_in_pos  <= s_axis_tdata[8:4];
            r_in_sym  <= s_axis_tdata[16:9];
            r_in_last <= s_axis_tlast;
        end
    end

    // Decode the executing beat into one-hot command enables.
    always_comb begin
        ctrl          = '0;
        ctrl.idx      = r_in_idx;
        ctrl.pos      = r_in_pos;
        ctrl.sym      = r_in_sym;
        ctrl.last     = r_in_last;
        if (go) begin
            case (ckc_pkg::t_op'(r_in_op))
                ckc_pkg::OP_CLEAR: ctrl.clear    = 1'b1;
                ckc_pkg::OP_LOAD:  ctrl.load     = 1'b1;
                ckc_pkg::OP_NODE:  ctrl.node     = 1'b1;
                ckc_pkg::OP_END:   ctrl.end_node = 1'b1;
                default: ;
            endcase
        end
    end

    ckc_pattern_store #(
        .NUM_PATTERNS       (NUM_PATTERNS),
        .MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_sym   (pat_sym),
        .o_rev   (pat_rev),
        .o_len   (pat_len),
        .o_canon (pat_canon),
        .o_pal   (pat_pal)
    );

    ckc_scan #(
        .NUM_PATTERNS       (NUM_PATTERNS),
        .MAX_PATTERN_LENGTH (MAX_PATTERN_LENGTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_sym   (pat_sym),
        .i_rev   (pat_rev),
        .i_len   (pat_len),
        .i_canon (pat_canon),
        .i_pal   (pat_pal),
        .o_count (counts)
    );

    // Count read mux; an index beyond the pattern set reads as zero.
    always_comb begin
        read_count = '0;
        for (int p = 0; p < NUM_PATTERNS; p++) begin
            read_count = read_count | (counts[p] & {ckc_pkg::COUNT_W{int'(r_in_idx) == p}});
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && is_read) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && is_read) begin
            r_out_idx   <= r_in_idx;
            r_out_count <= read_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_count, r_out_idx};

    // A read beat that executes always shows up as a result in the next cycle.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && is_read) |=> m_axis_tvalid)
        else $error("executed read produced no result beat");

    // An empty input register never refuses a beat.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input refused while input register empty");

    // A held read never executes while the result register is full and stalled.
    a_read_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && is_read && r_out_valid && !m_axis_tready) |-> (!go && !s_axis_tready))
        else $error("read executed into a stalled result register");

    // A non-read beat in the input register never blocks the input.
    a_nonread_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !is_read) |-> s_axis_tready)
        else $error("non-read beat stalled the input");

endmodule

`default_nettype wire

// ----- sim/ckc_stream_checker.sv -----
// Scoreboard for the canonical k-mer segment counter: watches both stream ports,
// keeps its own copy of the pattern store, window and counts, and compares reads.
// Depends on ckc_pkg for the opcodes, nucleotide bytes and count limits.
`timescale 1ns / 1ps

module ckc_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // pattern_index[3:0], position[8:4], symbol[16:9], zero
    input  logic [2:0]  i_s_tuser,   // opcode[2:0]
    input  logic        i_s_tlast,   // last_symbol
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // read_index[3:0], match_count[34:4], zero
    output int          o_fail_count,
    output int          o_pending,
    output int          o_reads_checked,
    output int          o_nonzero_reads
);

    localparam int                 NUM_KMERS = 16;
    localparam int                 KMER_MAX  = 32;
    localparam int                 COUNT_W   = ckc_pkg::COUNT_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = ckc_pkg::COUNT_MAX;

    typedef struct packed {
        logic [3:0]         idx;
        logic [COUNT_W-1:0] count;
    } t_count_read;

    // Expected read beats, oldest first.
    t_count_read        count_reads_due[$];

    // Mirror of the pattern store, the sliding window and the counters.
    logic [7:0]         kmer_sym   [NUM_KMERS][KMER_MAX];
    int                 kmer_len   [NUM_KMERS];
    bit                 kmer_canon [NUM_KMERS];
    bit                 kmer_palin [NUM_KMERS];
    logic [COUNT_W-1:0] kmer_count [NUM_KMERS];
    logic [7:0]         window_sym [KMER_MAX];
    int                 window_fill;

    function automatic logic [7:0] base_pair(input logic [7:0] b);
        if (b == ckc_pkg::SYM_A) return ckc_pkg::SYM_T;
        if (b == ckc_pkg::SYM_T) return ckc_pkg::SYM_A;
        if (b == ckc_pkg::SYM_G) return ckc_pkg::SYM_C;
        if (b == ckc_pkg::SYM_C) return ckc_pkg::SYM_G;
        return ckc_pkg::SYM_N;
    endfunction

    // Compare a completed pattern with its reverse complement, first byte first.
    function automatic void grade_kmer(input int p);
        int         order;
        int         len;
        logic [7:0] rc;
        order = 0;
        len   = kmer_len[p];
        for (int j = 0; j < len; j++) begin
            rc = base_pair(kmer_sym[p][len - 1 - j]);
            if (order == 0 && kmer_sym[p][j] != rc)
                order = (kmer_sym[p][j] < rc) ? -1 : 1;
        end
        kmer_canon[p] = (order <= 0);
        kmer_palin[p] = (order == 0);
    endfunction

    // Match every canonical pattern against the newest symbols of the window.
    function automatic void scan_window();
        int         len;
        bit         fwd;
        bit         rev;
        logic [1:0] hits;
        logic [7:0] w;
        for (int p = 0; p < NUM_KMERS; p++) begin
            len = kmer_len[p];
            if (len != 0 && len <= window_fill && kmer_canon[p]) begin
                fwd = 1'b1;
                rev = 1'b1;
                for (int j = 0; j < len; j++) begin
                    w = window_sym[len - 1 - j];
                    if (kmer_sym[p][j] != w) fwd = 1'b0;
                    if (base_pair(kmer_sym[p][len - 1 - j]) != w) rev = 1'b0;
                end
                hits = 2'(fwd) + 2'(rev && !kmer_palin[p]);
                if (kmer_count[p] > COUNT_MAX - COUNT_W'(hits))
                    kmer_count[p] = COUNT_MAX;
                else
                    kmer_count[p] = kmer_count[p] + COUNT_W'(hits);
            end
        end
    endfunction

    // Apply one accepted command beat to the mirror.
    function automatic void apply_command(input logic [2:0] op, input logic [3:0] idx,
                                          input logic [4:0] pos, input logic [7:0] sym,
                                          input logic last);
        t_count_read due;
        case (op)
            ckc_pkg::OP_CLEAR: begin
                for (int p = 0; p < NUM_KMERS; p++) kmer_count[p] = '0;
            end
            ckc_pkg::OP_LOAD: begin
                kmer_sym[idx][pos] = sym;
                if (last) begin
                    kmer_len[idx] = int'(pos) + 1;
                    grade_kmer(int'(idx));
                end else begin
                    kmer_len[idx]   = 0;
                    kmer_canon[idx] = 1'b0;
                    kmer_palin[idx] = 1'b0;
                end
            end
            ckc_pkg::OP_NODE: begin
                for (int i = KMER_MAX - 1; i > 0; i--) window_sym[i] = window_sym[i - 1];
                window_sym[0] = sym;
                if (window_fill < KMER_MAX) window_fill++;
                scan_window();
            end
            ckc_pkg::OP_END: begin
                for (int i = 0; i < KMER_MAX; i++) window_sym[i] = '0;
                window_fill = 0;
            end
            ckc_pkg::OP_READ: begin
                due.idx   = idx;
                due.count = kmer_count[idx];
                count_reads_due.push_back(due);
            end
            default: ;
        endcase
    endfunction

    // Result beats are checked before the command beat of the same edge is applied,
    // since a result always belongs to an earlier command.
    always @(posedge i_clk) begin
        t_count_read want;
        if (!i_rst_n) begin
            count_reads_due.delete();
            for (int p = 0; p < NUM_KMERS; p++) begin
                kmer_len[p]   = 0;
                kmer_canon[p] = 1'b0;
                kmer_palin[p] = 1'b0;
                kmer_count[p] = '0;
                for (int j = 0; j < KMER_MAX; j++) kmer_sym[p][j] = '0;
            end
            for (int i = 0; i < KMER_MAX; i++) window_sym[i] = '0;
            window_fill = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (count_reads_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result beat with no read pending: index %0d count %0d",
                                 $realtime, i_m_tdata[3:0], i_m_tdata[34:4]);
                end else begin
                    want = count_reads_due.pop_front();
                    o_reads_checked++;
                    if (want.count != 0) o_nonzero_reads++;
                    if (i_m_tdata[3:0] !== want.idx || i_m_tdata[34:4] !== want.count) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: read mismatch: index exp %0d got %0d,",
                                      " count exp %0d got %0d"},
                                     $realtime, want.idx, i_m_tdata[3:0],
                                     want.count, i_m_tdata[34:4]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                apply_command(i_s_tuser, i_s_tdata[3:0], i_s_tdata[8:4],
                              i_s_tdata[16:9], i_s_tlast);
        end
        o_pending = count_reads_due.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the canonical k-mer segment counter testbench: clock, reset, command
// stimulus with random gaps, result back-pressure and the final verdict.
// Depends on ckc_pkg, canonical_kmer_segment_counter and ckc_stream_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int          CYCLE_LIMIT = 600000;
    localparam int          RANDOM_CMDS = 1400;
    localparam logic [2:0]  OP_SPARE_LO = 3'd5;
    localparam logic [2:0]  OP_SPARE_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // pattern_index[3:0], position[8:4], symbol[16:9], zero
    logic [2:0]  s_tuser;   // opcode[2:0]
    logic        s_tlast;   // last_symbol
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // read_index[3:0], match_count[34:4], zero

    int          fail_count;
    int          reads_due;
    int          reads_checked;
    int          nonzero_reads;
    int          cycles;
    int          commands_sent;
    bit          src_burst;
    bit          sink_burst;

    // What the stimulus side knows about each pattern slot, for embedding matches.
    logic [7:0]  slot_txt [16][32];
    int          slot_len [16];
    logic [31:0] slot_written [16];

    canonical_kmer_segment_counter dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    ckc_stream_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (reads_due),
        .o_reads_checked (reads_checked),
        .o_nonzero_reads (nonzero_reads)
    );

    // 100 MHz clock.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d reads outstanding", cycles, reads_due);
            $display("[canonical_kmer_segment_counter] ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] comp_base(input logic [7:0] b);
        case (b)
            ckc_pkg::SYM_A: return ckc_pkg::SYM_T;
            ckc_pkg::SYM_T: return ckc_pkg::SYM_A;
            ckc_pkg::SYM_G: return ckc_pkg::SYM_C;
            ckc_pkg::SYM_C: return ckc_pkg::SYM_G;
            default:        return ckc_pkg::SYM_N;
        endcase
    endfunction

    function automatic logic [7:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return ckc_pkg::SYM_A;
            1:       return ckc_pkg::SYM_C;
            2:       return ckc_pkg::SYM_G;
            default: return ckc_pkg::SYM_T;
        endcase
    endfunction

    // Mostly nucleotides, now and then an n or an arbitrary byte.
    function automatic logic [7:0] pick_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) return pick_base();
        if (r < 94) return ckc_pkg::SYM_N;
        return 8'($urandom_range(0, 255));
    endfunction

    // Drive one command beat after a random gap and hold it until accepted.
    // Called and returns at a falling edge.
    task automatic send_command(input logic [2:0] op, input logic [3:0] idx,
                                input logic [4:0] pos, input logic [7:0] sym,
                                input logic last);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {7'd0, sym, pos, idx};
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (op < OP_SPARE_LO) commands_sent++;
        if (op == ckc_pkg::OP_LOAD) begin
            slot_txt[idx][pos] = sym;
            slot_written[idx][pos] = 1'b1;
            slot_len[idx] = last ? int'(pos) + 1 : 0;
        end
    endtask

    // Hold the sender off until every read has come back.
    task automatic drain_reads();
        s_tvalid = 1'b0;
        while (reads_due != 0) @(negedge clk);
    endtask

    // Load a pattern in position order; it may be cut short without its last symbol.
    task automatic load_kmer(input logic [3:0] idx, input int len, input bit mirror,
                             input bit cut_short);
        logic [7:0] txt [32];
        int         stop;
        for (int j = 0; j < len; j++) txt[j] = pick_symbol();
        if (mirror) begin
            for (int j = 0; j < len / 2; j++) begin
                txt[j] = pick_base();
                txt[len - 1 - j] = comp_base(txt[j]);
            end
            if (len % 2 == 1) txt[len / 2] = ckc_pkg::SYM_N;
        end
        stop = cut_short ? $urandom_range(0, len - 1) : len;
        for (int j = 0; j < stop; j++)
            send_command(ckc_pkg::OP_LOAD, idx, 5'(j), txt[j], !cut_short && j == len - 1);
    endtask

    // Stream node symbols, embedding stored patterns or their reverse complements.
    task automatic run_node(input int want);
        int         done;
        int         p;
        int         len;
        bit         as_rc;
        logic [7:0] sym;
        done = 0;
        while (done < want) begin
            p = $urandom_range(0, 15);
            len = slot_len[p];
            if ($urandom_range(0, 3) == 0 && len > 0) begin
                as_rc = $urandom_range(0, 1);
                for (int j = 0; j < len; j++) begin
                    sym = as_rc ? comp_base(slot_txt[p][len - 1 - j]) : slot_txt[p][j];
                    send_command(ckc_pkg::OP_NODE, 4'($urandom_range(0, 15)),
                                 5'($urandom_range(0, 31)), sym, 1'($urandom_range(0, 1)));
                end
                done += len;
            end else begin
                send_command(ckc_pkg::OP_NODE, 4'($urandom_range(0, 15)),
                             5'($urandom_range(0, 31)), pick_symbol(),
                             1'($urandom_range(0, 1)));
                done++;
            end
        end
        if ($urandom_range(0, 3) != 0)
            send_command(ckc_pkg::OP_END, 4'($urandom_range(0, 15)),
                         5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 5);
        if (r < 95) return $urandom_range(6, 12);
        return $urandom_range(13, 32);
    endfunction

    // Result side: random stalls per beat, with stretches of none.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Command stimulus and verdict.
    initial begin
        int         sel;
        logic [3:0] idx;
        logic [4:0] pos;
        logic       last;
        logic [31:0] lower;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ckc_pkg::OP_CLEAR;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        for (int p = 0; p < 16; p++) begin
            slot_len[p] = 0;
            slot_written[p] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: count of an untouched slot, a palindrome closed by a last mark,
        // single-symbol patterns on both sides of canonical, zero and all-ones bytes.
        send_command(ckc_pkg::OP_READ, 4'd0, 5'd0, 8'd0, 1'b0);
        send_command(ckc_pkg::OP_LOAD, 4'd0, 5'd0, ckc_pkg::SYM_A, 1'b0);
        send_command(ckc_pkg::OP_LOAD, 4'd0, 5'd1, ckc_pkg::SYM_C, 1'b0);
        send_command(ckc_pkg::OP_LOAD, 4'd0, 5'd2, ckc_pkg::SYM_G, 1'b0);
        send_command(ckc_pkg::OP_LOAD, 4'd0, 5'd3, ckc_pkg::SYM_T, 1'b1);
        send_command(ckc_pkg::OP_LOAD, 4'd15, 5'd0, ckc_pkg::SYM_A, 1'b1);
        send_command(ckc_pkg::OP_LOAD, 4'd1, 5'd0, ckc_pkg::SYM_T, 1'b1);
        send_command(ckc_pkg::OP_LOAD, 4'd2, 5'd0, 8'h00, 1'b1);
        send_command(ckc_pkg::OP_LOAD, 4'd3, 5'd0, 8'hFF, 1'b1);
        send_command(ckc_pkg::OP_LOAD, 4'd4, 5'd31, ckc_pkg::SYM_G, 1'b0);
        send_command(ckc_pkg::OP_NODE, 4'd0, 5'd0, ckc_pkg::SYM_A, 1'b0);
        send_command(ckc_pkg::OP_NODE, 4'd0, 5'd0, ckc_pkg::SYM_C, 1'b0);
        send_command(ckc_pkg::OP_NODE, 4'd0, 5'd0, ckc_pkg::SYM_G, 1'b0);
        send_command(ckc_pkg::OP_NODE, 4'd0, 5'd0, ckc_pkg::SYM_T, 1'b0);
        send_command(ckc_pkg::OP_NODE, 4'd15, 5'd31, 8'h00, 1'b1);
        send_command(OP_SPARE_HI, 4'd15, 5'd31, 8'hFF, 1'b1);
        send_command(ckc_pkg::OP_READ, 4'd0, 5'd0, 8'd0, 1'b0);
        send_command(ckc_pkg::OP_READ, 4'd15, 5'd0, 8'd0, 1'b0);
        send_command(ckc_pkg::OP_READ, 4'd2, 5'd0, 8'd0, 1'b0);
        send_command(ckc_pkg::OP_END, 4'd0, 5'd0, 8'd0, 1'b0);
        send_command(ckc_pkg::OP_NODE, 4'd0, 5'd0, ckc_pkg::SYM_T, 1'b0);
        send_command(ckc_pkg::OP_READ, 4'd15, 5'd0, 8'd0, 1'b0);
        send_command(ckc_pkg::OP_CLEAR, 4'd0, 5'd0, 8'd0, 1'b0);
        send_command(ckc_pkg::OP_READ, 4'd15, 5'd0, 8'd0, 1'b0);
        drain_reads();

        // Random: fill every slot, then mix loads, node runs, reads, clears, drains and noise.
        for (int p = 0; p < 16; p++)
            load_kmer(4'(p), pick_length(), $urandom_range(0, 4) == 0, 1'b0);
        while (commands_sent < RANDOM_CMDS) begin
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                load_kmer(4'($urandom_range(0, 15)), pick_length(),
                          $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
            end else if (sel < 65) begin
                run_node($urandom_range(1, 40));
            end else if (sel < 82) begin
                repeat ($urandom_range(1, 4))
                    send_command(ckc_pkg::OP_READ, 4'($urandom_range(0, 15)),
                                 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
            end else if (sel < 85) begin
                send_command(ckc_pkg::OP_CLEAR, 4'($urandom_range(0, 15)),
                             5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end else if (sel < 88) begin
                drain_reads();
            end else begin
                idx  = 4'($urandom_range(0, 15));
                pos  = 5'($urandom_range(0, 31));
                last = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 2))
                    0: send_command(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), idx, pos,
                                    8'($urandom_range(0, 255)), last);
                    1: begin
                        // Stray load: a last mark only where every lower position is written.
                        lower = (32'd1 << pos) - 32'd1;
                        if ((slot_written[idx] & lower) != lower) last = 1'b0;
                        send_command(ckc_pkg::OP_LOAD, idx, pos, 8'($urandom_range(0, 255)),
                                     last);
                    end
                    default: send_command(ckc_pkg::OP_END, idx, pos,
                                          8'($urandom_range(0, 255)), last);
                endcase
            end
        end

        s_tvalid = 1'b0;
        while (reads_due != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Coverage: %0d command beats (all opcodes, patterns of 1 to 32 symbols,",
                 commands_sent);
        $display("palindromes, stray loads), %0d count reads compared, %0d of them nonzero.",
                 reads_checked, nonzero_reads);
        if (fail_count == 0 && reads_due == 0)
            $display("[canonical_kmer_segment_counter] OK");
        else
            $display("[canonical_kmer_segment_counter] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/ckc_pkg.sv
design/ckc_pattern_store.sv
design/ckc_scan.sv
design/canonical_kmer_segment_counter.sv
sim/ckc_stream_checker.sv
sim/tb_top.sv
